@@ rtl/sbs_pkg.sv @@
// Shared types, constants and byte classes for the sentence boundary splitter.
// No dependencies; used by sbs_rec_if and every module under rtl/.
package sbs_pkg;

  localparam int unsigned POS_BITS   = 20;
  localparam int unsigned COUNT_BITS = 16;

  localparam logic [POS_BITS-1:0]   POS_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  // Room for the item in the input register and the one being accepted.
  localparam logic [FIFO_CW-1:0] FIFO_ACCEPT_MAX = FIFO_CW'(FIFO_DEPTH - 4);

  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       text_last;
  } char_t;

  typedef struct packed {
    logic [POS_BITS-1:0]   start_pos;
    logic [POS_BITS-1:0]   end_pos;
    logic [COUNT_BITS-1:0] word_count;
    logic                  blank;
    logic                  text_end;
    logic                  run_last;
    logic                  overflow;
  } rec_t;

  // Records produced by one item, in order: rec0 first, rec1 only when cnt is 2.
  typedef struct packed {
    logic [1:0] cnt;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

  function automatic logic is_trim_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_c_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == CH_PERIOD) || (c == CH_BANG) || (c == CH_QUEST);
  endfunction

endpackage

@@ rtl/sbs_if.sv @@
// Valid/ready channel interfaces: text bytes in, sentence records out.
// Depends on sbs_pkg for field widths.
interface sbs_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       text_last;

  modport source (output valid, char_byte, text_last, input ready);
  modport sink   (input valid, char_byte, text_last, output ready);
endinterface

interface sbs_rec_if;
  import sbs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [POS_BITS-1:0]   start_pos;
  logic [POS_BITS-1:0]   end_pos;
  logic [COUNT_BITS-1:0] word_count;
  logic                  blank;
  logic                  text_end;
  logic                  run_last;
  logic                  overflow;

  modport source (output valid, start_pos, end_pos, word_count, blank, text_end,
                  run_last, overflow, input ready);
  modport sink   (input valid, start_pos, end_pos, word_count, blank, text_end,
                  run_last, overflow, output ready);
endinterface

@@ rtl/sbs_scan.sv @@
// Input register and per-byte scanner: segment state, boundary decision, records.
// Depends on sbs_pkg.
module sbs_scan (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  sbs_pkg::char_t char_i,
  output sbs_pkg::push_t push_o
);
  import sbs_pkg::*;

  logic                  in_valid_q;
  char_t                 in_q;

  logic [POS_BITS-1:0]   byte_pos_q, byte_pos_d;
  logic [POS_BITS-1:0]   first_q, first_d;
  logic [POS_BITS-1:0]   last_q, last_d;
  logic                  has_q, has_d;
  logic [COUNT_BITS-1:0] words_q, words_d;
  logic                  inword_q, inword_d;
  logic                  punct_q, punct_d;
  logic                  prev_nl_q, prev_nl_d;
  logic                  ovf_q, ovf_d;
  push_t                 push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      in_q <= char_i;
    end
  end

  always_comb begin
    logic [7:0]          c;
    logic [POS_BITS-1:0] pos;
    logic                boundary;
    logic                rec0_en;

    c        = in_q.char_byte;
    pos      = byte_pos_q;
    boundary = 1'b0;
    rec0_en  = 1'b0;

    byte_pos_d = byte_pos_q;
    first_d    = first_q;
    last_d     = last_q;
    has_d      = has_q;
    words_d    = words_q;
    inword_d   = inword_q;
    punct_d    = punct_q;
    prev_nl_d  = prev_nl_q;
    ovf_d      = ovf_q;
    push       = '0;

    if (in_valid_q) begin
      if (byte_pos_q == POS_MAX) begin
        ovf_d = 1'b1;
      end else begin
        byte_pos_d = byte_pos_q + POS_BITS'(1);
      end

      if (punct_q) begin
        if (c != CH_SPACE) begin
          punct_d = 1'b0;
          boundary = ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) || (c == CH_LF);
        end
      end else if (prev_nl_q) begin
        boundary = (c == CH_LF);
      end
      prev_nl_d = 1'b0;

      push.rec0.start_pos  = first_q;
      push.rec0.end_pos    = last_q;
      push.rec0.word_count = words_q;
      rec0_en = boundary && has_q;

      if (boundary) begin
        first_d  = '0;
        last_d   = '0;
        has_d    = 1'b0;
        words_d  = '0;
        inword_d = 1'b0;
      end

      if (!is_trim_space(c)) begin
        if (!has_d) begin
          first_d = pos;
        end
        has_d  = 1'b1;
        last_d = pos;
      end

      if (is_c_space(c)) begin
        inword_d = 1'b0;
      end else if (!inword_d) begin
        inword_d = 1'b1;
        if (words_d == CNT_MAX) begin
          ovf_d = 1'b1;
        end else begin
          words_d = words_d + COUNT_BITS'(1);
        end
      end

      if (is_punct(c)) begin
        punct_d = 1'b1;
      end
      if (c == CH_LF) begin
        prev_nl_d = 1'b1;
      end

      push.rec1.start_pos  = has_d ? first_d : '0;
      push.rec1.end_pos    = has_d ? last_d : '0;
      push.rec1.word_count = has_d ? words_d : '0;
      push.rec1.blank      = !has_d;
      push.rec1.text_end   = 1'b1;
      push.rec1.run_last   = 1'b1;
      push.rec1.overflow   = ovf_d;

      push.rec0.blank    = 1'b0;
      push.rec0.text_end = 1'b0;
      push.rec0.run_last = !in_q.text_last;
      push.rec0.overflow = ovf_d;

      // Move the text-end record into the first slot when it is alone.
      if (rec0_en && in_q.text_last) begin
        push.cnt = 2'd2;
      end else if (rec0_en) begin
        push.cnt = 2'd1;
      end else if (in_q.text_last) begin
        push.cnt  = 2'd1;
        push.rec0 = push.rec1;
      end else begin
        push.cnt = 2'd0;
      end

      if (in_q.text_last) begin
        byte_pos_d = '0;
        first_d    = '0;
        last_d     = '0;
        has_d      = 1'b0;
        words_d    = '0;
        inword_d   = 1'b0;
        punct_d    = 1'b0;
        prev_nl_d  = 1'b0;
        ovf_d      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q <= '0;
      first_q    <= '0;
      last_q     <= '0;
      has_q      <= 1'b0;
      words_q    <= '0;
      inword_q   <= 1'b0;
      punct_q    <= 1'b0;
      prev_nl_q  <= 1'b0;
      ovf_q      <= 1'b0;
    end else begin
      byte_pos_q <= byte_pos_d;
      first_q    <= first_d;
      last_q     <= last_d;
      has_q      <= has_d;
      words_q    <= words_d;
      inword_q   <= inword_d;
      punct_q    <= punct_d;
      prev_nl_q  <= prev_nl_d;
      ovf_q      <= ovf_d;
    end
  end

  assign push_o = push;

endmodule

@@ rtl/sbs_outq.sv @@
// Result queue: takes up to two records per cycle, hands out one per cycle while ready_i is high.
// Depends on sbs_pkg.
module sbs_outq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sbs_pkg::push_t                 push_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output sbs_pkg::rec_t                  rec_o,
  output logic [sbs_pkg::FIFO_CW-1:0]    count_o
);
  import sbs_pkg::*;

  rec_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] head_q, head_d;
  logic [FIFO_AW-1:0] tail_q, tail_d;
  logic [FIFO_CW-1:0] count_q, count_d;
  logic               pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;
  assign rec_o   = mem_q[head_q];
  assign count_o = count_q;

  always_comb begin
    head_d  = head_q + FIFO_AW'(pop);
    tail_d  = tail_q + FIFO_AW'(push_i.cnt);
    count_d = count_q + FIFO_CW'(push_i.cnt) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[tail_q] <= push_i.rec0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[tail_q + FIFO_AW'(1)] <= push_i.rec1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

endmodule

@@ rtl/sentence_boundary_splitter.sv @@
// Sentence boundary splitter top level: input channel, scanner, result queue.
// Depends on sbs_pkg, sbs_if, sbs_scan and sbs_outq.
//
// Usage: text enters on in_i one byte per item, text_last high on the final
// byte. Each sentence that is not blank leaves on out_o as one item holding
// the positions of its first and last non-blank byte and its word count; the
// final byte of a text always yields an item with text_end high (blank high
// when only spaces, tabs, LF or CR remained). One byte can yield up to two
// items; run_last marks the last of them.
// Throughput: one byte per cycle while in_i.ready is high. An accepted byte is
// registered in the input register, scanned in the next cycle, and its records
// are written into the result queue, from which out_o presents them in order.
// The output queue holds eight records; in_i.ready drops when five or more
// are waiting, so a stalled receiver stops intake without losing records,
// and intake resumes once the receiver drains the queue to four or fewer.
// Reset clears the scanner state and the queue; the next byte starts a new
// text at position 0.
module sentence_boundary_splitter (
  input  logic      clk_i,
  input  logic      rst_ni,
  sbs_char_if.sink  in_i,
  sbs_rec_if.source out_o
);
  import sbs_pkg::*;

  logic               accept;
  char_t              char_in;
  push_t              push;
  rec_t               rec;
  logic [FIFO_CW-1:0] count;

  assign in_i.ready = (count <= FIFO_ACCEPT_MAX);
  assign accept     = in_i.valid && in_i.ready;

  assign char_in.char_byte = in_i.char_byte;
  assign char_in.text_last = in_i.text_last;

  sbs_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .char_i   (char_in),
    .push_o   (push)
  );

  sbs_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .rec_o   (rec),
    .count_o (count)
  );

  assign out_o.start_pos  = rec.start_pos;
  assign out_o.end_pos    = rec.end_pos;
  assign out_o.word_count = rec.word_count;
  assign out_o.blank      = rec.blank;
  assign out_o.text_end   = rec.text_end;
  assign out_o.run_last   = rec.run_last;
  assign out_o.overflow   = rec.overflow;

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue over capacity");

  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.text_end |-> out_o.run_last)
    else $error("text end record not last of its byte");

  a_blank_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.blank |-> (out_o.text_end && out_o.word_count == '0
                                    && out_o.start_pos == '0))
    else $error("blank record carries content");

  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.run_last |=> out_o.valid)
    else $error("second record of a byte missing");

endmodule
